// File: src/gafrsp_pkg.sv
`timescale 1ns / 1ps

package gafrsp_pkg;

  localparam int VALUE_WIDTH   = 64;
  localparam int FIELDS_NEEDED = 12;
  localparam int FIELD_STRAND  = 4;
  localparam int FIELD_WALK    = 5;
  localparam int FIELD_MAPQ    = 11;

  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [1:0] {
    KIND_NUMBER,
    KIND_NODE,
    KIND_STRAND,
    KIND_END
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK,
    ST_SKIPPED,
    ST_TOO_FEW,
    ST_BAD_NUMBER,
    ST_BAD_STRAND,
    ST_BAD_ORIENT,
    ST_MISSING_ID
  } status_t;

  typedef struct packed {
    kind_t       kind;
    logic [3:0]  field;
    logic [63:0] value;
    logic        rev;
    status_t     status;
    logic        last;
  } res_t;

endpackage

// File: src/gafrsp_in_if.sv
`timescale 1ns / 1ps

interface gafrsp_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] char_byte;

  modport source (output valid, output req_type, output char_byte, input ready);
  modport sink   (input valid, input req_type, input char_byte, output ready);
endinterface

// File: src/gafrsp_out_if.sv
`timescale 1ns / 1ps

interface gafrsp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [3:0]  field_number;
  logic [63:0] value;
  logic        node_reverse;
  logic [2:0]  line_status;
  logic        last_of_line;

  modport source (output valid, output result_kind, output field_number, output value,
                  output node_reverse, output line_status, output last_of_line,
                  input ready);
  modport sink   (input valid, input result_kind, input field_number, input value,
                  input node_reverse, input line_status, input last_of_line,
                  output ready);
endinterface

// File: src/gaf_record_stream_parser.sv
`timescale 1ns / 1ps

// GAF alignment record parser.
// in_ch carries one beat per line byte (req_type 0, char_byte) or an
// end-of-line marker (req_type 1). out_ch carries results: numeric fields,
// walk nodes, the strand and one record-end beat per line with its status.
// Each input beat is decoded in the cycle it is accepted; its results are
// registered in the result queue and show on out_ch from there. A byte beat
// gives at most one result, a line end up to two, delivered on consecutive beats.
// Sustained rate is one input beat per cycle while the receiver keeps up; the
// four-entry result queue sets how far ahead input can run. in_ch.ready drops
// while the queue holds three or more results, so a stalled receiver stops the
// input with at most four results buffered. Nothing is lost or reordered under stalls.
// Synchronous active-low reset clears the line state and empties the queue.
module gaf_record_stream_parser (
  input  logic         clk,
  input  logic         rst_n,
  gafrsp_in_if.sink    in_ch,
  gafrsp_out_if.source out_ch
);

  localparam int VW = gafrsp_pkg::VALUE_WIDTH;

  typedef enum logic [1:0] {
    MODE_NONE,
    MODE_COMMENT,
    MODE_RECORD
  } mode_t;

  logic [3:0]          fc_r, fc_nxt;
  logic [VW-1:0]       acc_r, acc_nxt;
  logic                digits_r, digits_nxt;
  gafrsp_pkg::status_t err_r, err_nxt;
  mode_t               mode_r, mode_nxt;
  logic                walk_r, walk_nxt;
  logic                rev_r, rev_nxt;
  logic [1:0]          slen_r, slen_nxt;

  logic                accept;
  logic                room;
  logic                push0, push1;
  gafrsp_pkg::res_t    d0, d1, end_res, fin_res, node_res, q_out;
  logic                fin_emit;
  gafrsp_pkg::status_t fin_err;
  logic [7:0]          c;
  logic                in_field;
  logic                is_digit, is_orient;
  logic [VW+3:0]       ext_acc, prod;
  logic [3:0]          dval;
  logic                ovf;

  assign accept      = in_ch.valid && in_ch.ready;
  assign in_ch.ready = room;
  assign c           = in_ch.char_byte;
  assign in_field    = (err_r == gafrsp_pkg::ST_OK) && (fc_r != 4'd0) &&
                       (fc_r < 4'(gafrsp_pkg::FIELDS_NEEDED));
  assign is_digit    = (c >= gafrsp_pkg::CH_ZERO) && (c <= gafrsp_pkg::CH_NINE);
  assign is_orient   = (c == gafrsp_pkg::CH_GT) || (c == gafrsp_pkg::CH_LT);

  // acc*10 + d; overflow when anything lands above the value width
  assign dval    = c[3:0];
  assign ext_acc = {4'b0, acc_r};
  assign prod    = (ext_acc << 3) + (ext_acc << 1) + {{VW{1'b0}}, dval};
  assign ovf     = |prod[VW+3:VW];

  assign node_res = '{kind: gafrsp_pkg::KIND_NODE, field: fc_r, value: 64'(acc_r),
                      rev: rev_r, status: gafrsp_pkg::ST_OK, last: 1'b0};

  // Completion of the current field, from the current state
  always_comb begin
    fin_emit = 1'b0;
    fin_err  = err_r;
    fin_res  = '{kind: gafrsp_pkg::KIND_NUMBER, field: fc_r, value: 64'(acc_r),
                 rev: 1'b0, status: gafrsp_pkg::ST_OK, last: 1'b0};
    if (in_field) begin
      if (fc_r == 4'(gafrsp_pkg::FIELD_STRAND)) begin
        fin_res.kind = gafrsp_pkg::KIND_STRAND;
        if (slen_r != 2'd1) begin
          fin_err = gafrsp_pkg::ST_BAD_STRAND;
        end else begin
          fin_emit = 1'b1;
        end
      end else if (fc_r == 4'(gafrsp_pkg::FIELD_WALK)) begin
        fin_res = node_res;
        if (walk_r) begin
          if (!digits_r) begin
            fin_err = gafrsp_pkg::ST_MISSING_ID;
          end else begin
            fin_emit = 1'b1;
          end
        end
      end else begin
        if (!digits_r) begin
          fin_err = gafrsp_pkg::ST_BAD_NUMBER;
        end else begin
          fin_emit = 1'b1;
          if (fc_r == 4'(gafrsp_pkg::FIELD_MAPQ)) begin
            fin_res.value = {32'b0, acc_r[31:0]};
          end
        end
      end
    end
  end

  always_comb begin
    fc_nxt     = fc_r;
    acc_nxt    = acc_r;
    digits_nxt = digits_r;
    err_nxt    = err_r;
    mode_nxt   = mode_r;
    walk_nxt   = walk_r;
    rev_nxt    = rev_r;
    slen_nxt   = slen_r;
    push0      = 1'b0;
    push1      = 1'b0;
    end_res    = '{kind: gafrsp_pkg::KIND_END, field: 4'd0, value: 64'd0,
                   rev: 1'b0, status: gafrsp_pkg::ST_SKIPPED, last: 1'b1};
    d0         = fin_res;
    d1         = end_res;

    if (accept) begin
      if (in_ch.req_type) begin
        if (mode_r == MODE_RECORD) begin
          // too few fields wins over any recorded error
          end_res.status = (fc_r < 4'(gafrsp_pkg::FIELDS_NEEDED - 1)) ?
                           gafrsp_pkg::ST_TOO_FEW : fin_err;
        end
        push0 = 1'b1;
        if (mode_r == MODE_RECORD && fin_emit) begin
          d0    = fin_res;
          d1    = end_res;
          push1 = 1'b1;
        end else begin
          d0 = end_res;
        end
        fc_nxt     = '0;
        acc_nxt    = '0;
        digits_nxt = 1'b0;
        err_nxt    = gafrsp_pkg::ST_OK;
        mode_nxt   = MODE_NONE;
        walk_nxt   = 1'b0;
        rev_nxt    = 1'b0;
        slen_nxt   = '0;
      end else if ((mode_r == MODE_NONE && c != gafrsp_pkg::CH_HASH) ||
                   mode_r == MODE_RECORD) begin
        mode_nxt = MODE_RECORD;
        if (c == gafrsp_pkg::CH_TAB) begin
          if (fc_r < 4'(gafrsp_pkg::FIELDS_NEEDED)) begin
            push0      = fin_emit;
            d0         = fin_res;
            err_nxt    = fin_err;
            fc_nxt     = fc_r + 4'd1;
            acc_nxt    = '0;
            digits_nxt = 1'b0;
            walk_nxt   = 1'b0;
            rev_nxt    = 1'b0;
            slen_nxt   = '0;
          end
        end else if (in_field) begin
          if (fc_r == 4'(gafrsp_pkg::FIELD_STRAND)) begin
            if (slen_r != 2'd0 ||
                (c != gafrsp_pkg::CH_PLUS && c != gafrsp_pkg::CH_MINUS)) begin
              err_nxt = gafrsp_pkg::ST_BAD_STRAND;
            end else begin
              acc_nxt = VW'(c == gafrsp_pkg::CH_MINUS);
            end
            if (slen_r != 2'd2) begin
              slen_nxt = slen_r + 2'd1;
            end
          end else if (fc_r == 4'(gafrsp_pkg::FIELD_WALK) && (!walk_r || is_orient)) begin
            if (!is_orient) begin
              err_nxt = gafrsp_pkg::ST_BAD_ORIENT;
            end else if (walk_r && !digits_r) begin
              err_nxt = gafrsp_pkg::ST_MISSING_ID;
            end else begin
              // an orientation byte closes the previous node, if any
              push0      = walk_r;
              d0         = node_res;
              walk_nxt   = 1'b1;
              rev_nxt    = (c == gafrsp_pkg::CH_LT);
              acc_nxt    = '0;
              digits_nxt = 1'b0;
            end
          end else begin
            if (!is_digit || ovf) begin
              err_nxt = gafrsp_pkg::ST_BAD_NUMBER;
            end else begin
              acc_nxt    = prod[VW-1:0];
              digits_nxt = 1'b1;
            end
          end
        end
      end else if (mode_r == MODE_NONE) begin
        mode_nxt = MODE_COMMENT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fc_r     <= '0;
      acc_r    <= '0;
      digits_r <= 1'b0;
      err_r    <= gafrsp_pkg::ST_OK;
      mode_r   <= MODE_NONE;
      walk_r   <= 1'b0;
      rev_r    <= 1'b0;
      slen_r   <= '0;
    end else begin
      fc_r     <= fc_nxt;
      acc_r    <= acc_nxt;
      digits_r <= digits_nxt;
      err_r    <= err_nxt;
      mode_r   <= mode_nxt;
      walk_r   <= walk_nxt;
      rev_r    <= rev_nxt;
      slen_r   <= slen_nxt;
    end
  end

  gafrsp_res_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push0      (push0),
    .push1      (push1),
    .din0       (d0),
    .din1       (d1),
    .room       (room),
    .dout_valid (out_ch.valid),
    .dout_ready (out_ch.ready),
    .dout       (q_out)
  );

  assign out_ch.result_kind  = q_out.kind;
  assign out_ch.field_number = q_out.field;
  assign out_ch.value        = q_out.value;
  assign out_ch.node_reverse = q_out.rev;
  assign out_ch.line_status  = q_out.status;
  assign out_ch.last_of_line = q_out.last;

endmodule

// File: src/gafrsp_res_fifo.sv
`timescale 1ns / 1ps

// Four-entry result queue; takes up to two results a cycle, gives one.
module gafrsp_res_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push0,
  input  logic              push1,
  input  gafrsp_pkg::res_t  din0,
  input  gafrsp_pkg::res_t  din1,
  output logic              room,
  output logic              dout_valid,
  input  logic              dout_ready,
  output gafrsp_pkg::res_t  dout
);

  gafrsp_pkg::res_t mem_r [4];
  logic [1:0] wr_ptr_r, wr_ptr_nxt;
  logic [1:0] rd_ptr_r, rd_ptr_nxt;
  logic [2:0] count_r, count_nxt;
  logic       pop;
  logic [1:0] wr_ptr_p1;

  assign pop        = dout_valid && dout_ready;
  assign dout_valid = (count_r != 3'd0);
  assign dout       = mem_r[rd_ptr_r];
  assign room       = (count_r < 3'd3);
  assign wr_ptr_p1  = wr_ptr_r + 2'd1;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + {1'b0, push0} + {1'b0, push1};
    rd_ptr_nxt = rd_ptr_r + {1'b0, pop};
    count_nxt  = count_r + {2'b0, push0} + {2'b0, push1} - {2'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push0) begin
      mem_r[wr_ptr_r] <= din0;
    end
    if (push1) begin
      mem_r[wr_ptr_p1] <= din1;
    end
  end

endmodule

// File: sim/gaf_result_checker.sv
`timescale 1ns / 1ps

module gaf_result_checker
  import gafrsp_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  gafrsp_in_if  in_mon,
  gafrsp_out_if out_mon,
  output int    fail_count,
  output int    pending
);

  typedef enum logic [1:0] {
    LINE_FRESH,
    LINE_COMMENT,
    LINE_RECORD
  } line_mode_t;

  localparam logic [63:0] VALUE_MAX = {64{1'b1}} >> (64 - VALUE_WIDTH);

  // parser state
  logic [3:0]  tab_count;
  logic [63:0] dec_value;
  logic        have_digit;
  status_t     line_err;
  line_mode_t  mode;
  logic        in_node_id;
  logic        node_rev;
  logic [1:0]  strand_bytes;

  res_t expected_results[$];

  function automatic void clear_field_state();
    dec_value    = '0;
    have_digit   = 1'b0;
    in_node_id   = 1'b0;
    node_rev     = 1'b0;
    strand_bytes = '0;
  endfunction

  function automatic void reset_line();
    tab_count = '0;
    line_err  = ST_OK;
    mode      = LINE_FRESH;
    clear_field_state();
  endfunction

  function automatic void flag_error(status_t code);
    if (line_err == ST_OK) begin
      line_err = code;
    end
  endfunction

  function automatic void push_result(kind_t k, logic [3:0] f, logic [63:0] v, logic r,
                                      status_t s, logic l);
    res_t item;
    item.kind   = k;
    item.field  = f;
    item.value  = v;
    item.rev    = r;
    item.status = s;
    item.last   = l;
    expected_results.insert(expected_results.size(), item);
  endfunction

  function automatic void add_decimal_digit(logic [7:0] c);
    logic [63:0] d;
    if (c < CH_ZERO || c > CH_NINE) begin
      flag_error(ST_BAD_NUMBER);
      return;
    end
    d = {56'b0, c - CH_ZERO};
    // overflow is flagged at the byte that would carry past the width
    if (dec_value > (VALUE_MAX - d) / 64'd10) begin
      flag_error(ST_BAD_NUMBER);
      return;
    end
    dec_value  = dec_value * 64'd10 + d;
    have_digit = 1'b1;
  endfunction

  function automatic void close_field();
    if (line_err != ST_OK || tab_count == 0 || tab_count >= FIELDS_NEEDED) begin
      return;
    end
    if (tab_count == FIELD_STRAND) begin
      if (strand_bytes != 2'd1) begin
        flag_error(ST_BAD_STRAND);
      end else begin
        push_result(KIND_STRAND, tab_count, dec_value, 1'b0, ST_OK, 1'b0);
      end
    end else if (tab_count == FIELD_WALK) begin
      if (!in_node_id) begin
        return;
      end
      if (!have_digit) begin
        flag_error(ST_MISSING_ID);
      end else begin
        push_result(KIND_NODE, tab_count, dec_value, node_rev, ST_OK, 1'b0);
      end
    end else if (!have_digit) begin
      flag_error(ST_BAD_NUMBER);
    end else if (tab_count == FIELD_MAPQ) begin
      push_result(KIND_NUMBER, tab_count, {32'b0, dec_value[31:0]}, 1'b0, ST_OK, 1'b0);
    end else begin
      push_result(KIND_NUMBER, tab_count, dec_value, 1'b0, ST_OK, 1'b0);
    end
  endfunction

  function automatic void take_line_byte(logic [7:0] c);
    logic is_orient;
    is_orient = (c == CH_GT) || (c == CH_LT);
    if (line_err != ST_OK || tab_count == 0 || tab_count >= FIELDS_NEEDED) begin
      return;
    end
    if (tab_count == FIELD_STRAND) begin
      if (strand_bytes != 0 || (c != CH_PLUS && c != CH_MINUS)) begin
        flag_error(ST_BAD_STRAND);
      end else begin
        dec_value = (c == CH_MINUS) ? 64'd1 : 64'd0;
      end
      if (strand_bytes < 2) begin
        strand_bytes++;
      end
      return;
    end
    if (tab_count == FIELD_WALK) begin
      if (!in_node_id) begin
        if (!is_orient) begin
          flag_error(ST_BAD_ORIENT);
          return;
        end
      end else if (is_orient) begin
        // next orientation closes the node being read
        if (!have_digit) begin
          flag_error(ST_MISSING_ID);
          return;
        end
        push_result(KIND_NODE, tab_count, dec_value, node_rev, ST_OK, 1'b0);
      end else begin
        add_decimal_digit(c);
        return;
      end
      in_node_id = 1'b1;
      node_rev   = (c == CH_LT);
      dec_value  = '0;
      have_digit = 1'b0;
      return;
    end
    add_decimal_digit(c);
  endfunction

  function automatic void parse_beat(logic rt, logic [7:0] c);
    status_t st;
    if (rt) begin
      if (mode != LINE_RECORD) begin
        st = ST_SKIPPED;
      end else begin
        close_field();
        st = (tab_count < FIELDS_NEEDED - 1) ? ST_TOO_FEW : line_err;
      end
      push_result(KIND_END, 4'd0, 64'd0, 1'b0, st, 1'b1);
      reset_line();
      return;
    end
    if (mode == LINE_FRESH) begin
      if (c == CH_HASH) begin
        mode = LINE_COMMENT;
        return;
      end
      mode = LINE_RECORD;
    end
    if (mode != LINE_RECORD) begin
      return;
    end
    if (c == CH_TAB) begin
      if (tab_count < FIELDS_NEEDED) begin
        close_field();
        tab_count++;
        clear_field_state();
      end
      return;
    end
    take_line_byte(c);
  endfunction

  task automatic check_result();
    res_t got;
    res_t want;
    got.kind   = kind_t'(out_mon.result_kind);
    got.field  = out_mon.field_number;
    got.value  = out_mon.value;
    got.rev    = out_mon.node_reverse;
    got.status = status_t'(out_mon.line_status);
    got.last   = out_mon.last_of_line;
    if (expected_results.size() == 0) begin
      fail_count++;
      if (fail_count <= 10) begin
        $display("%0t: unexpected beat kind=%0d field=%0d value=%0d rev=%0b status=%0d last=%0b",
                 $realtime, got.kind, got.field, got.value, got.rev, got.status, got.last);
      end
      return;
    end
    want = expected_results.pop_front();
    if (got !== want) begin
      fail_count++;
      if (fail_count <= 10) begin
        $display("%0t: mismatch exp kind=%0d field=%0d value=%0d rev=%0b status=%0d last=%0b",
                 $realtime, want.kind, want.field, want.value, want.rev, want.status,
                 want.last);
        $display("%0t:          got kind=%0d field=%0d value=%0d rev=%0b status=%0d last=%0b",
                 $realtime, got.kind, got.field, got.value, got.rev, got.status, got.last);
      end
    end
  endtask

  initial begin
    fail_count = 0;
    pending    = 0;
    reset_line();
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      reset_line();
      expected_results.delete();
    end else begin
      // results of a beat are registered before they show, so pop before push
      if (out_mon.valid && out_mon.ready) begin
        check_result();
      end
      if (in_mon.valid && in_mon.ready) begin
        parse_beat(in_mon.req_type, in_mon.char_byte);
      end
    end
    pending = expected_results.size();
  end

endmodule

// File: sim/gaf_record_stream_parser_test.sv
`timescale 1ns / 1ps

module gaf_record_stream_parser_test;
  import gafrsp_pkg::*;

  localparam int IDLE_LIMIT   = 4000;
  localparam int RANDOM_ITEMS = 550;

  logic clk;
  logic rst_n;
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  int   beats_sent     = 0;
  int   quiet_cycles   = 0;
  int   fail_count;
  int   pending;
  int   rand_start;

  logic [7:0] line_buf[$];

  gafrsp_in_if  in_ch();
  gafrsp_out_if out_ch();

  gaf_record_stream_parser u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  gaf_result_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
        $display("gaf_record_stream_parser_test failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // called and returns at a falling edge
  task automatic send_beat(logic rt, logic [7:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.req_type  <= rt;
    in_ch.char_byte <= c;
    @(posedge clk);
    while (!in_ch.ready) begin
      @(posedge clk);
    end
    @(negedge clk);
    beats_sent++;
  endtask

  task automatic send_line();
    foreach (line_buf[i]) begin
      send_beat(1'b0, line_buf[i]);
    end
    send_beat(1'b1, 8'($urandom_range(255)));
    line_buf.delete();
  endtask

  function automatic void add_byte(logic [7:0] b);
    line_buf.insert(line_buf.size(), b);
  endfunction

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) begin
      add_byte(s[i]);
    end
  endfunction

  function automatic void put_digits(int n);
    repeat (n) begin
      add_byte(8'(CH_ZERO + $urandom_range(9)));
    end
  endfunction

  function automatic void put_number();
    int r;
    r = $urandom_range(99);
    if (r < 55) begin
      put_digits($urandom_range(1, 3));
    end else if (r < 75) begin
      put_digits($urandom_range(4, 20));
    end else if (r < 82) begin
      put_text("18446744073709551615");
    end else if (r < 88) begin
      put_text("18446744073709551616");
    end else if (r < 92) begin
      // empty field
    end else if (r < 96) begin
      put_digits($urandom_range(0, 2));
      add_byte(8'($urandom_range(255)));
    end else begin
      put_text("99999999999999999999");
    end
  endfunction

  function automatic void put_strand();
    int r;
    r = $urandom_range(99);
    if (r < 88) begin
      add_byte($urandom_range(1) ? CH_MINUS : CH_PLUS);
    end else if (r < 92) begin
      // empty strand
    end else if (r < 96) begin
      add_byte(CH_PLUS);
      add_byte($urandom_range(1) ? CH_MINUS : CH_PLUS);
    end else begin
      add_byte(8'($urandom_range(255)));
    end
  endfunction

  function automatic void put_walk();
    int r;
    repeat ($urandom_range(0, 4)) begin
      r = $urandom_range(99);
      if (r < 3) begin
        add_byte(8'(CH_ZERO + $urandom_range(9)));
      end else begin
        add_byte($urandom_range(1) ? CH_LT : CH_GT);
      end
      if (r >= 3 && r < 7) begin
        continue;  // orientation with no id
      end
      if (r < 10) begin
        put_digits($urandom_range(0, 2));
        add_byte(8'($urandom_range(255)));
      end else if (r < 20) begin
        put_digits($urandom_range(7, 20));
      end else begin
        put_digits($urandom_range(1, 6));
      end
    end
  endfunction

  function automatic void build_record();
    int r;
    int nf;
    r = $urandom_range(99);
    if (r < 70) begin
      nf = FIELDS_NEEDED;
    end else if (r < 85) begin
      nf = $urandom_range(FIELDS_NEEDED + 1, FIELDS_NEEDED + 3);
    end else begin
      nf = $urandom_range(1, FIELDS_NEEDED - 1);
    end
    for (int f = 0; f < nf; f++) begin
      if (f > 0) begin
        add_byte(CH_TAB);
      end
      if (f == 0) begin
        repeat ($urandom_range(0, 4)) begin
          add_byte(8'($urandom_range(33, 126)));
        end
      end else if (f == FIELD_STRAND) begin
        put_strand();
      end else if (f == FIELD_WALK) begin
        put_walk();
      end else if (f >= FIELDS_NEEDED) begin
        repeat ($urandom_range(0, 4)) begin
          add_byte(8'($urandom_range(255)));
        end
      end else begin
        put_number();
      end
    end
    if (line_buf.size() > 0 && $urandom_range(99) < 8) begin
      line_buf[$urandom_range(line_buf.size() - 1)] = 8'($urandom_range(255));
    end
  endfunction

  function automatic void build_line();
    int r;
    r = $urandom_range(99);
    if (r < 4) begin
      // empty line
    end else if (r < 9) begin
      add_byte(CH_HASH);
      repeat ($urandom_range(0, 6)) begin
        add_byte(8'($urandom_range(255)));
      end
    end else if (r < 17) begin
      repeat ($urandom_range(1, 20)) begin
        r = $urandom_range(99);
        if (r < 30) begin
          add_byte(CH_TAB);
        end else if (r < 60) begin
          add_byte(8'(CH_ZERO + $urandom_range(9)));
        end else begin
          add_byte(8'($urandom_range(255)));
        end
      end
    end else begin
      build_record();
    end
  endfunction

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending != 0) begin
      @(negedge clk);
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.req_type  = 1'b0;
    in_ch.char_byte = 8'h00;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty line, comment line, then a minimal complete record
    send_line();
    put_text("#\t");
    send_line();
    put_text("\t0\t0\t0\t-\t<9\t0\t0\t0\t0\t0\t0");
    send_line();
    wait_drained();

    rand_start = beats_sent;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 74;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 74;
        end
        default: begin
          send_idle_pct  = 35;
          recv_stall_pct = 35;
        end
      endcase
      while (beats_sent - rand_start < (phase + 1) * RANDOM_ITEMS / 4) begin
        build_line();
        send_line();
      end
      wait_drained();
    end

    repeat (8) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("gaf_record_stream_parser_test passed");
    end else begin
      $display("gaf_record_stream_parser_test failed");
    end
    $finish;
  end

endmodule

// File: gaf_record_stream_parser.f
src/gafrsp_pkg.sv
src/gafrsp_in_if.sv
src/gafrsp_out_if.sv
src/gafrsp_res_fifo.sv
src/gaf_record_stream_parser.sv
sim/gaf_result_checker.sv
sim/gaf_record_stream_parser_test.sv
